[design/asdp_pkg.sv]
// ----------------------------------------------------------------------------
// asdp_pkg
// Types and character constants shared by the ASCII signed decimal parser.
// ----------------------------------------------------------------------------
`default_nettype none

package asdp_pkg;

    localparam int unsigned CH_WIDTH     = 8;
    localparam int unsigned SCALED_WIDTH = 32;
    localparam int unsigned FRAC_WIDTH   = 8;

    localparam logic [CH_WIDTH-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CH_WIDTH-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CH_WIDTH-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CH_WIDTH-1:0] CHAR_POINT = 8'h2e;
    localparam logic [CH_WIDTH-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CH_WIDTH-1:0] CHAR_SPACE = 8'h20;

    typedef enum logic [2:0] {
        CC_DIGIT,
        CC_SPACE,
        CC_NUL,
        CC_POINT,
        CC_MINUS,
        CC_OTHER
    } t_char_class;

    typedef struct packed {
        logic [CH_WIDTH-1:0] ch;
        logic                last;
    } t_item;

    typedef struct packed {
        logic signed [SCALED_WIDTH-1:0] scaled_value;
        logic [FRAC_WIDTH-1:0]          frac_digits;
        logic                           bad_char;
    } t_result;

    function automatic t_char_class classify(input logic [CH_WIDTH-1:0] c);
        t_char_class cls;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            cls = CC_DIGIT;
        end else if (c == CHAR_SPACE) begin
            cls = CC_SPACE;
        end else if (c == CHAR_NUL) begin
            cls = CC_NUL;
        end else if (c == CHAR_POINT) begin
            cls = CC_POINT;
        end else if (c == CHAR_MINUS) begin
            cls = CC_MINUS;
        end else begin
            cls = CC_OTHER;
        end
        return cls;
    endfunction

endpackage

`default_nettype wire

[design/asdp_in_if.sv]
// ----------------------------------------------------------------------------
// asdp_in_if
// Character channel: valid/ready handshake with one ASCII character per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface asdp_in_if
    import asdp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CH_WIDTH-1:0] ch;
    logic                last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

[design/asdp_out_if.sv]
// ----------------------------------------------------------------------------
// asdp_out_if
// Result channel: valid/ready handshake with one parsed number per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface asdp_out_if
    import asdp_pkg::*;
();
    logic                           valid;
    logic                           ready;
    logic signed [SCALED_WIDTH-1:0] scaled_value;
    logic [FRAC_WIDTH-1:0]          frac_digits;
    logic                           bad_char;

    modport source (output valid, output scaled_value, output frac_digits,
                    output bad_char, input ready);
    modport sink   (input valid, input scaled_value, input frac_digits,
                    input bad_char, output ready);
endinterface

`default_nettype wire

[design/asdp_in_stage.sv]
// ----------------------------------------------------------------------------
// asdp_in_stage
// Input register; holds one character until the parser core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module asdp_in_stage
    import asdp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    asdp_in_if.sink   i_in,
    input  wire logic i_advance,
    output logic      o_valid,
    output t_item     o_item
);

    logic  r_valid;
    t_item r_item;

    assign i_in.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.ch   <= i_in.ch;
            r_item.last <= i_in.last;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

[design/asdp_core.sv]
// ----------------------------------------------------------------------------
// asdp_core
// Field state and per-character update; forms the result on the last character.
// ----------------------------------------------------------------------------
`default_nettype none

module asdp_core
    import asdp_pkg::*;
#(
    parameter int unsigned ACC_WIDTH = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_advance,
    input  wire t_item  i_item,
    output t_result     o_result
);

    logic [ACC_WIDTH-1:0]  r_acc,   n_acc;
    logic [FRAC_WIDTH-1:0] r_frac,  n_frac;
    logic                  r_point, n_point;
    logic                  r_neg,   n_neg;
    logic                  r_done,  n_done;
    logic                  r_err,   n_err;
    logic                  r_first, n_first;
    logic                  r_after, n_after;

    t_char_class          cls;
    logic [ACC_WIDTH-1:0] acc_x10;
    logic [ACC_WIDTH-1:0] digit;

    assign cls     = classify(i_item.ch);
    assign acc_x10 = (r_acc << 3) + (r_acc << 1);
    assign digit   = {{(ACC_WIDTH-4){1'b0}}, i_item.ch[3:0]};

    always_comb begin
        n_acc   = r_acc;
        n_frac  = r_frac;
        n_point = r_point;
        n_neg   = r_neg;
        n_done  = r_done;
        n_err   = r_err;
        n_first = r_first;
        n_after = r_after;
        // characters after an end NUL or an error are dropped
        if (!r_done && !r_err) begin
            n_first = 1'b0;
            unique case (cls)
                CC_DIGIT, CC_SPACE: begin
                    if (r_point) begin
                        n_frac = r_frac + 1'b1;
                    end
                    if (cls == CC_DIGIT) begin
                        n_acc = r_neg ? acc_x10 - digit : acc_x10 + digit;
                    end
                    n_after = 1'b1;
                end
                CC_NUL: begin
                    if (r_after) begin
                        n_done = 1'b1;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                CC_POINT: begin
                    n_point = 1'b1;
                    n_after = 1'b0;
                end
                CC_MINUS: begin
                    if (r_first) begin
                        n_neg   = 1'b1;
                        n_after = 1'b0;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                default: begin
                    n_err = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_result.bad_char     = n_err;
        o_result.scaled_value = n_err ? '0 : SCALED_WIDTH'($signed(n_acc));
        o_result.frac_digits  = n_err ? '0 : n_frac;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_item.last)) begin
            r_acc   <= '0;
            r_frac  <= '0;
            r_point <= 1'b0;
            r_neg   <= 1'b0;
            r_done  <= 1'b0;
            r_err   <= 1'b0;
            r_first <= 1'b1;
            r_after <= 1'b0;
        end else if (i_advance) begin
            r_acc   <= n_acc;
            r_frac  <= n_frac;
            r_point <= n_point;
            r_neg   <= n_neg;
            r_done  <= n_done;
            r_err   <= n_err;
            r_first <= n_first;
            r_after <= n_after;
        end
    end

endmodule

`default_nettype wire

[design/asdp_out_stage.sv]
// ----------------------------------------------------------------------------
// asdp_out_stage
// Result register; holds one parsed number until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module asdp_out_stage
    import asdp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    output logic         o_free,
    asdp_out_if.source   o_out
);

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.scaled_value = r_result.scaled_value;
    assign o_out.frac_digits  = r_result.frac_digits;
    assign o_out.bad_char     = r_result.bad_char;

endmodule

`default_nettype wire

[design/ascii_signed_decimal_parser_top.sv]
// ----------------------------------------------------------------------------
// ascii_signed_decimal_parser_top
// Parses a signed decimal text field, one ASCII character per request.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle while the result side does not stall;
// a character passes an input register, is folded into the accumulator by a
// shift-add times ten, and on the character flagged last the result lands in
// an output register, from which it is offered to the sink. The only
// stall comes from the result side: while a result waits untaken, the input
// register fills and then holds. The field value is scaled_value divided by
// ten to the power frac_digits; bad_char set means the field held an illegal
// character and the other fields read zero. The accumulator is ACC_WIDTH
// bits and wraps; scaled_value is its low 32 bits, sign-extended.
`default_nettype none

module ascii_signed_decimal_parser_top
    import asdp_pkg::*;
#(
    parameter int unsigned ACC_WIDTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    asdp_in_if.sink    i_in,
    asdp_out_if.source o_out
);

    logic    in_valid;
    t_item   in_item;
    logic    out_free;
    logic    advance;
    t_result result;

    // the held character moves on only when a result could be stored
    assign advance = in_valid && out_free;

    asdp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_item    (in_item)
    );

    asdp_core #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (in_item),
        .o_result  (result)
    );

    asdp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && in_item.last),
        .i_result (result),
        .o_free   (out_free),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

[tb/asdp_number_check.sv]
// ----------------------------------------------------------------------------
// asdp_number_check
// Watches both channels of the decimal parser, folds every accepted character
// into its own copy of the parse state and compares each result request
// field by field with the oldest expected number.
// ----------------------------------------------------------------------------

module asdp_number_check
    import asdp_pkg::*;
#(
    parameter int unsigned ACC_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    asdp_in_if   i_char_ch,
    asdp_out_if  i_num_ch,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_results,
    output int   o_bad_results
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [ACC_WIDTH-1:0]  acc;
    logic [FRAC_WIDTH-1:0] frac_cnt;
    logic                  point_seen;
    logic                  negative;
    logic                  ended;
    logic                  bad_seen;
    logic                  first_char;
    logic                  after_digit;

    t_result expected_nums[$];
    int      fail_count;
    int      result_count;
    int      bad_count;

    task automatic clear_number();
        acc         = '0;
        frac_cnt    = '0;
        point_seen  = 1'b0;
        negative    = 1'b0;
        ended       = 1'b0;
        bad_seen    = 1'b0;
        first_char  = 1'b1;
        after_digit = 1'b0;
    endtask

    task automatic fold_char(input logic [CH_WIDTH-1:0] c);
        t_char_class          cls;
        logic [ACC_WIDTH-1:0] d;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            cls = CC_DIGIT;
        end else if (c == CHAR_SPACE) begin
            cls = CC_SPACE;
        end else if (c == CHAR_NUL) begin
            cls = CC_NUL;
        end else if (c == CHAR_POINT) begin
            cls = CC_POINT;
        end else if (c == CHAR_MINUS) begin
            cls = CC_MINUS;
        end else begin
            cls = CC_OTHER;
        end
        // once ended or broken, the rest of the field is ignored
        if (!ended && !bad_seen) begin
            if (cls == CC_DIGIT || cls == CC_SPACE) begin
                if (point_seen) begin
                    frac_cnt = frac_cnt + 1'b1;
                end
                if (cls == CC_DIGIT) begin
                    d   = ACC_WIDTH'(c - CHAR_ZERO);
                    acc = negative ? acc * 10 - d : acc * 10 + d;
                end
                after_digit = 1'b1;
            end else if (cls == CC_NUL && after_digit) begin
                ended = 1'b1;
            end else if (cls == CC_POINT) begin
                point_seen  = 1'b1;
                after_digit = 1'b0;
            end else if (cls == CC_MINUS && first_char) begin
                negative    = 1'b1;
                after_digit = 1'b0;
            end else begin
                bad_seen = 1'b1;
            end
            first_char = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_number();
            expected_nums.delete();
            fail_count   = 0;
            result_count = 0;
            bad_count    = 0;
        end else begin
            if (i_num_ch.valid && i_num_ch.ready) begin
                result_count++;
                if (i_num_ch.bad_char) begin
                    bad_count++;
                end
                if (expected_nums.size() == 0) begin
                    $error("unexpected result: scaled_value %0d frac_digits %0d bad_char %0b",
                           i_num_ch.scaled_value, i_num_ch.frac_digits, i_num_ch.bad_char);
                    fail_count++;
                end else begin
                    want = expected_nums.pop_front();
                    if (i_num_ch.scaled_value !== want.scaled_value) begin
                        $error("scaled_value mismatch: expected %0d, actual %0d",
                               want.scaled_value, i_num_ch.scaled_value);
                        fail_count++;
                    end
                    if (i_num_ch.frac_digits !== want.frac_digits) begin
                        $error("frac_digits mismatch: expected %0d, actual %0d",
                               want.frac_digits, i_num_ch.frac_digits);
                        fail_count++;
                    end
                    if (i_num_ch.bad_char !== want.bad_char) begin
                        $error("bad_char mismatch: expected %0b, actual %0b",
                               want.bad_char, i_num_ch.bad_char);
                        fail_count++;
                    end
                end
            end
            if (i_char_ch.valid && i_char_ch.ready) begin
                fold_char(i_char_ch.ch);
                if (i_char_ch.last) begin
                    want.bad_char = bad_seen;
                    if (bad_seen) begin
                        want.scaled_value = '0;
                        want.frac_digits  = '0;
                    end else begin
                        // low bits of the accumulator, sign-extended when narrower
                        want.scaled_value = SCALED_WIDTH'(signed'(acc));
                        want.frac_digits  = frac_cnt;
                    end
                    expected_nums.push_back(want);
                    clear_number();
                end
            end
        end
        o_fail_count  <= fail_count;
        o_pending     <= expected_nums.size();
        o_results     <= result_count;
        o_bad_results <= bad_count;
    end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives text fields into the decimal parser with random gaps and stalls on
// both channels, one long result hold-off, and reports the verdict of the
// number checker.
// ----------------------------------------------------------------------------

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import asdp_pkg::*;

    localparam int ACC_WIDTH    = 32;
    localparam int CHAR_TARGET  = 1950;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AT      = 40;
    localparam int DRAIN_CYCLES = 10;
    localparam int LONG_FRAC    = 300;

    typedef logic [CH_WIDTH-1:0] t_char_q[$];

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   result_count;
    int   bad_count;
    int   chars_sent;
    int   fields_sent;
    int   send_mode;
    int   cycle_count;

    asdp_in_if  char_ch ();
    asdp_out_if num_ch ();

    ascii_signed_decimal_parser_top #(
        .ACC_WIDTH(ACC_WIDTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (char_ch),
        .o_out  (num_ch)
    );

    asdp_number_check #(
        .ACC_WIDTH(ACC_WIDTH)
    ) u_number_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char_ch    (char_ch),
        .i_num_ch     (num_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (result_count),
        .o_bad_results(bad_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // mode 0: back to back, 1: uniform 0..8, 2: mostly back to back
    function automatic int draw_gap(input int mode);
        int gap;
        case (mode)
            1: begin
                gap = $urandom_range(0, 8);
            end
            2: begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
            end
            default: begin
                gap = 0;
            end
        endcase
        return gap;
    endfunction

    function automatic logic [CH_WIDTH-1:0] digit_or_space();
        logic [CH_WIDTH-1:0] c;
        if ($urandom_range(0, 7) == 0) begin
            c = CHAR_SPACE;
        end else begin
            c = CHAR_ZERO + CH_WIDTH'($urandom_range(0, 9));
        end
        return c;
    endfunction

    function automatic t_char_q text_to_chars(input string s);
        t_char_q f;
        for (int i = 0; i < s.len(); i++) begin
            f.push_back(s[i]);
        end
        return f;
    endfunction

    // sign, integer part, optional fraction, optional ending nul plus junk
    function automatic t_char_q make_number();
        t_char_q f;
        int      n;
        if ($urandom_range(0, 2) == 0) begin
            f.push_back(CHAR_MINUS);
        end
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6);
        repeat (n) f.push_back(digit_or_space());
        if ($urandom_range(0, 1) == 1) begin
            f.push_back(CHAR_POINT);
            if ($urandom_range(0, 7) == 0) begin
                f.push_back(CHAR_POINT);
            end
            repeat ($urandom_range(0, 5)) f.push_back(digit_or_space());
        end
        if (f.size() == 0) begin
            f.push_back(digit_or_space());
        end
        if ((f[f.size()-1] == CHAR_SPACE || f[f.size()-1] >= CHAR_ZERO)
                && $urandom_range(0, 5) == 0) begin
            f.push_back(CHAR_NUL);
            repeat ($urandom_range(0, 3)) f.push_back(CH_WIDTH'($urandom_range(0, 255)));
        end
        return f;
    endfunction

    function automatic t_char_q make_field();
        t_char_q f;
        int      kind;
        int      pos;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            f = make_number();
        end else if (kind < 85) begin
            // a well-formed number with one character spoiled
            f = make_number();
            pos = $urandom_range(0, f.size() - 1);
            case ($urandom_range(0, 3))
                0: f[pos] = CHAR_MINUS;
                1: f[pos] = CHAR_NUL;
                2: f[pos] = CHAR_POINT;
                default: f[pos] = CH_WIDTH'($urandom_range(0, 255));
            endcase
        end else begin
            repeat ($urandom_range(1, 6)) begin
                f.push_back(CH_WIDTH'($urandom_range(0, 255)));
            end
        end
        return f;
    endfunction

    task automatic send_char(input logic [CH_WIDTH-1:0] c, input logic is_last);
        int gap;
        gap = draw_gap(send_mode);
        if (gap > 0) begin
            char_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_ch.valid <= 1'b1;
        char_ch.ch    <= c;
        char_ch.last  <= is_last;
        do @(posedge i_clk); while (!char_ch.ready);
        chars_sent++;
    endtask

    task automatic send_field(input t_char_q f);
        foreach (f[i]) begin
            send_char(f[i], i == f.size() - 1);
        end
        fields_sent++;
    endtask

    initial begin
        t_char_q f;
        char_ch.valid <= 1'b0;
        char_ch.ch    <= '0;
        char_ch.last  <= 1'b0;
        i_rst_n       <= 1'b0;
        chars_sent  = 0;
        fields_sent = 0;
        send_mode   = 1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // largest positive value, lone minus, illegal letter, late minus
        send_field(text_to_chars("2147483647"));
        send_field(text_to_chars("-"));
        send_field(text_to_chars("1x"));
        send_field(text_to_chars("1-"));
        // nul after a digit ends the field, nul as first char is illegal
        send_char(CHAR_ZERO + 8'd5, 1'b0);
        send_char(CHAR_NUL, 1'b0);
        send_char(CHAR_ZERO + 8'd9, 1'b1);
        send_char(CHAR_NUL, 1'b1);
        // second point is harmless, space after the point counts
        send_field(text_to_chars("1.. 2"));

        while (chars_sent < CHAR_TARGET) begin
            if (fields_sent % 40 == 0) begin
                send_mode = $urandom_range(0, 2);
            end
            case (fields_sent)
                8: f = text_to_chars("-2147483648");
                9: f = text_to_chars("2147483648");
                12: begin
                    // fraction count wraps past 255
                    f = text_to_chars("1.");
                    repeat (LONG_FRAC) f.push_back(digit_or_space());
                end
                default: f = make_field();
            endcase
            send_field(f);
        end
        char_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d characters in %0d fields, including overflow, nul end and wrap",
                 chars_sent, fields_sent);
        $display("checked %0d numbers, %0d of them flagged with an illegal character",
                 result_count, bad_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // result side: random stalls, plus one long hold-off to back up the input
    initial begin
        int gap;
        int taken;
        int recv_mode;
        num_ch.ready <= 1'b0;
        taken     = 0;
        recv_mode = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (taken % 30 == 0) begin
                recv_mode = $urandom_range(0, 2);
            end
            gap = (taken == HOLD_AT) ? LONG_HOLD : draw_gap(recv_mode);
            if (gap > 0) begin
                num_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            num_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!num_ch.valid);
            taken++;
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
